FILE: hw/rtl/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    // Default screen geometry.
    localparam int TCW_ROWS = 25;
    localparam int TCW_COLS = 80;

    // Character codes and the power-on attribute.
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] RESET_ATTR = 8'h07;

    // Operation codes carried in the mode field.
    localparam logic [1:0] MODE_PUT_CHAR   = 2'd0;
    localparam logic [1:0] MODE_SET_CURSOR = 2'd1;
    localparam logic [1:0] MODE_CLEAR      = 2'd2;
    localparam logic [1:0] MODE_READ_CELL  = 2'd3;

    // One command transaction.
    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  char_code;
        logic [4:0]  new_row;
        logic [6:0]  new_column;
        logic [7:0]  new_color;
        logic [10:0] cell_index;
        logic        last_in_call;
    } t_item;

    // One result transaction.
    typedef struct packed {
        logic [7:0]  read_char;
        logic [7:0]  read_attr;
        logic [4:0]  cursor_row_now;
        logic [6:0]  cursor_column_now;
        logic        wrote_cell;
        logic [10:0] written_index;
        logic        scrolled;
        logic        call_done;
    } t_result;

endpackage

`default_nettype wire

FILE: hw/rtl/tcw_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Simple dual-port store with a registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/text_console_writer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Text console engine with an internal screen store of ROWS x COLS cells, each
// holding a character byte (low half) and an attribute byte (high half).
// Commands arrive on i_item and are taken when i_start is high and o_busy is low.
// Every command gives exactly one result on o_result, marked by o_valid for a
// single cycle; the receiver cannot stall, so results are never held back.
// Printable characters, line controls and set-cursor commands without a scroll
// give their result in the cycle after acceptance and may be issued every cycle.
// A read-cell command gives its result after passing through S_READ, as the
// screen store has a registered read port.
// A scroll or a clear sweeps the screen store through its read and write
// ports, one cell per cycle, with o_busy high; it then passes through S_FINISH,
// which registers the result.
// The default colour register is written through i_cfg_we / i_cfg_data at any
// time the engine is idle.
// After reset the engine fills every cell with a space and attribute 7 while
// o_busy is high; the cursor starts at row 1, column 0.
module text_console_writer_core
    import tcw_pkg::*;
#(
    parameter int ROWS = TCW_ROWS,
    parameter int COLS = TCW_COLS
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    output logic            o_busy,
    input  wire t_item      i_item,
    output logic            o_valid,
    output t_result         o_result,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_data
);

    localparam int CELLS     = ROWS * COLS;
    localparam int IW        = $clog2(CELLS);
    localparam int PW        = $clog2(CELLS + 1);
    localparam int RW        = $clog2(ROWS);
    localparam int CW        = $clog2(COLS + 1);
    localparam int LAST_BASE = (ROWS - 1) * COLS;

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SWEEP  = 3'd2;
    localparam logic [2:0] S_FINISH = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [PW-1:0] r_ptr, n_ptr;
    logic          r_wvalid, n_wvalid;
    logic [IW-1:0] r_waddr, n_waddr;
    logic          r_wtail, n_wtail;
    logic          r_clr, n_clr;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [7:0]    r_color, n_color;
    logic [7:0]    r_dflt, n_dflt;
    t_result       r_pend, n_pend;
    logic          r_pwrite, n_pwrite;
    logic [7:0]    r_pch, n_pch;
    logic          r_rd_ok, n_rd_ok;
    logic          r_valid, n_valid;
    t_result       r_res, n_res;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic [IW-1:0] mem_raddr;
    logic [15:0]   mem_rdata;

    logic          accept;
    logic          is_lf, is_cr, printable, wrap, row_inc, need_scroll, tail;
    logic [RW-1:0] row_at;
    logic [CW-1:0] col_at;
    logic [IW-1:0] widx;
    t_result       res;

    assign accept   = i_start && (r_state == S_IDLE);
    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;

    // Screen store: attribute in the upper byte, character in the lower byte.
    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Decode of a put-character transaction against the current cursor.
    always_comb begin
        is_lf       = (i_item.char_code == CH_LF);
        is_cr       = (i_item.char_code == CH_CR);
        printable   = !is_lf && !is_cr;
        wrap        = (int'(r_col) >= COLS);
        row_inc     = is_lf || (printable && wrap);
        need_scroll = row_inc && (int'(r_row) == ROWS - 1);
        if (need_scroll) begin
            row_at = RW'(ROWS - 1);
        end else if (row_inc) begin
            row_at = r_row + RW'(1);
        end else begin
            row_at = r_row;
        end
        col_at = row_inc ? '0 : r_col;
        widx   = IW'(IW'(row_at) * IW'(COLS) + IW'(col_at));
    end

    // Sequencer: transaction decode, screen sweeps and result generation.
    always_comb begin
        n_state  = r_state;
        n_ptr    = r_ptr;
        n_wvalid = r_wvalid;
        n_waddr  = r_waddr;
        n_wtail  = r_wtail;
        n_clr    = r_clr;
        n_row    = r_row;
        n_col    = r_col;
        n_color  = r_color;
        n_dflt   = i_cfg_we ? i_cfg_data : r_dflt;
        n_pend   = r_pend;
        n_pwrite = r_pwrite;
        n_pch    = r_pch;
        n_rd_ok  = r_rd_ok;
        n_valid  = 1'b0;
        n_res    = r_res;

        mem_we    = 1'b0;
        mem_waddr = r_waddr;
        mem_wdata = '0;
        mem_raddr = IW'(r_ptr);
        tail      = 1'b0;
        res       = '0;

        case (r_state)
            S_INIT: begin
                // Power-on fill with spaces and the reset attribute.
                mem_we    = 1'b1;
                mem_waddr = IW'(r_ptr);
                mem_wdata = {RESET_ATTR, CH_SPACE};
                if (r_ptr == PW'(CELLS - 1)) begin
                    n_ptr   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + PW'(1);
                end
            end

            S_IDLE: begin
                mem_raddr = IW'(i_item.cell_index);
                if (accept) begin
                    res.call_done = i_item.last_in_call;
                    case (i_item.mode)
                        MODE_PUT_CHAR: begin
                            if (is_cr) begin
                                n_col = '0;
                            end else if (is_lf) begin
                                n_row = row_at;
                                n_col = '0;
                            end else begin
                                n_row             = row_at;
                                n_col             = col_at + CW'(1);
                                res.wrote_cell    = 1'b1;
                                res.written_index = 11'(widx);
                                if (!need_scroll) begin
                                    mem_we    = 1'b1;
                                    mem_waddr = widx;
                                    mem_wdata = {r_color, i_item.char_code};
                                end
                            end
                            res.scrolled = need_scroll;
                            if (need_scroll) begin
                                n_state  = S_SWEEP;
                                n_ptr    = PW'(COLS);
                                n_clr    = 1'b0;
                                n_wvalid = 1'b0;
                                n_pwrite = printable;
                                n_pch    = i_item.char_code;
                            end
                        end
                        MODE_SET_CURSOR: begin
                            n_row   = (int'(i_item.new_row) > ROWS - 1) ?
                                      RW'(ROWS - 1) : RW'(i_item.new_row);
                            n_col   = (int'(i_item.new_column) > COLS) ?
                                      CW'(COLS) : CW'(i_item.new_column);
                            n_color = i_item.new_color;
                        end
                        MODE_CLEAR: begin
                            n_state  = S_SWEEP;
                            n_ptr    = '0;
                            n_clr    = 1'b1;
                            n_wvalid = 1'b0;
                            n_pwrite = 1'b0;
                            n_row    = RW'(1);
                            n_col    = '0;
                            n_color  = r_dflt;
                        end
                        MODE_READ_CELL: begin
                            n_rd_ok = (int'(i_item.cell_index) < CELLS);
                            n_state = S_READ;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                    res.cursor_row_now    = 5'(n_row);
                    res.cursor_column_now = 7'(n_col);
                    n_pend = res;
                    if (n_state == S_IDLE) begin
                        n_valid = 1'b1;
                        n_res   = res;
                    end
                end
            end

            S_SWEEP: begin
                // Write back the cell read in the previous cycle.
                if (r_wvalid) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_waddr;
                    mem_wdata = r_wtail ? {mem_rdata[15:8], CH_SPACE} : mem_rdata;
                end
                // Issue the next read: a row copy from one row below, or a
                // blanking read of the cell itself on the last row or a clear.
                if (r_ptr != PW'(CELLS)) begin
                    tail      = r_clr || (r_ptr >= PW'(LAST_BASE));
                    mem_raddr = tail ? IW'(r_ptr) : IW'(r_ptr + PW'(COLS));
                    n_wvalid  = 1'b1;
                    n_waddr   = IW'(r_ptr);
                    n_wtail   = tail;
                    n_ptr     = r_ptr + PW'(1);
                end else begin
                    n_wvalid = 1'b0;
                    n_state  = S_FINISH;
                end
            end

            S_FINISH: begin
                // A character that caused the scroll lands at the last row start.
                if (r_pwrite) begin
                    mem_we    = 1'b1;
                    mem_waddr = IW'(LAST_BASE);
                    mem_wdata = {r_color, r_pch};
                end
                n_valid = 1'b1;
                n_res   = r_pend;
                n_state = S_IDLE;
            end

            S_READ: begin
                n_valid           = 1'b1;
                n_res             = r_pend;
                n_res.read_char   = r_rd_ok ? mem_rdata[7:0] : 8'd0;
                n_res.read_attr   = r_rd_ok ? mem_rdata[15:8] : 8'd0;
                n_state           = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state with synchronous reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_ptr    <= '0;
            r_wvalid <= 1'b0;
            r_clr    <= 1'b0;
            r_row    <= RW'(1);
            r_col    <= '0;
            r_color  <= RESET_ATTR;
            r_dflt   <= RESET_ATTR;
            r_pwrite <= 1'b0;
            r_rd_ok  <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_wvalid <= n_wvalid;
            r_clr    <= n_clr;
            r_row    <= n_row;
            r_col    <= n_col;
            r_color  <= n_color;
            r_dflt   <= n_dflt;
            r_pwrite <= n_pwrite;
            r_rd_ok  <= n_rd_ok;
            r_valid  <= n_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_waddr <= n_waddr;
        r_wtail <= n_wtail;
        r_pend  <= n_pend;
        r_pch   <= n_pch;
        r_res   <= n_res;
    end

endmodule

`default_nettype wire

FILE: bench/text_console_writer_core_tb.sv
`timescale 1ns / 1ps

module text_console_writer_core_tb;
    import tcw_pkg::*;

    localparam int CELLS       = TCW_ROWS * TCW_COLS;
    localparam int CYCLE_LIMIT = 12_000_000;
    localparam int PRINT_LIMIT = 40;
    localparam int PHASE_ITEMS = 340;

    // One row of the directed table: the command, and a hand-written result where one is given.
    typedef struct packed {
        t_item   cmd;
        logic    fixed;
        t_result res;
    } t_step_row;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_start    = 1'b0;
    t_item      i_item     = '0;
    logic       i_cfg_we   = 1'b0;
    logic [7:0] i_cfg_data = 8'h00;
    logic       o_busy;
    logic       o_valid;
    t_result    o_result;

    // Shadow copy of the screen and cursor.
    logic [7:0] screen_char [CELLS];
    logic [7:0] screen_attr [CELLS];
    int         cur_row;
    int         cur_col;
    logic [7:0] cur_color;
    logic [7:0] clear_color;
    int         last_written;

    // Console results still to arrive, oldest first.
    t_result    due_results [$];

    int err_count   = 0;
    int cycle_count = 0;
    int calm_left   = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    text_console_writer_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // Print one line per mismatch, up to a limit, and count every one.
    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (err_count < PRINT_LIMIT) begin
            $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $time);
        end
        err_count++;
    endtask

    task automatic compare_result(input t_result got, input t_result want);
        if (got.read_char !== want.read_char)
            report_mismatch("read_char", got.read_char, want.read_char);
        if (got.read_attr !== want.read_attr)
            report_mismatch("read_attr", got.read_attr, want.read_attr);
        if (got.cursor_row_now !== want.cursor_row_now)
            report_mismatch("cursor_row_now", got.cursor_row_now, want.cursor_row_now);
        if (got.cursor_column_now !== want.cursor_column_now)
            report_mismatch("cursor_column_now", got.cursor_column_now,
                            want.cursor_column_now);
        if (got.wrote_cell !== want.wrote_cell)
            report_mismatch("wrote_cell", got.wrote_cell, want.wrote_cell);
        if (got.written_index !== want.written_index)
            report_mismatch("written_index", got.written_index, want.written_index);
        if (got.scrolled !== want.scrolled)
            report_mismatch("scrolled", got.scrolled, want.scrolled);
        if (got.call_done !== want.call_done)
            report_mismatch("call_done", got.call_done, want.call_done);
    endtask

    // Scroll the shadow screen once the cursor has run off the last row.
    // Row 0 is left alone and the bottom row keeps its attributes.
    function automatic bit scroll_up();
        int i;
        if (cur_row < TCW_ROWS) return 1'b0;
        for (i = TCW_COLS; i < (TCW_ROWS - 1) * TCW_COLS; i++) begin
            screen_char[i] = screen_char[i + TCW_COLS];
            screen_attr[i] = screen_attr[i + TCW_COLS];
        end
        for (i = (TCW_ROWS - 1) * TCW_COLS; i < CELLS; i++) begin
            screen_char[i] = CH_SPACE;
        end
        cur_row = TCW_ROWS - 1;
        cur_col = 0;
        return 1'b1;
    endfunction

    // Apply one command to the shadow console and return the result it gives.
    function automatic t_result apply_command(input t_item cmd);
        t_result r;
        int      idx;
        r = '0;
        r.call_done = cmd.last_in_call;
        case (cmd.mode)
            MODE_PUT_CHAR: begin
                if (cmd.char_code == CH_LF) begin
                    cur_row++;
                    cur_col = 0;
                    r.scrolled = scroll_up();
                end else if (cmd.char_code == CH_CR) begin
                    cur_col = 0;
                end else begin
                    // A column resting at the right edge means a wrap is pending.
                    if (cur_col >= TCW_COLS) begin
                        cur_row++;
                        cur_col = 0;
                    end
                    r.scrolled = scroll_up();
                    idx = cur_row * TCW_COLS + cur_col;
                    screen_char[idx] = cmd.char_code;
                    screen_attr[idx] = cur_color;
                    r.wrote_cell     = 1'b1;
                    r.written_index  = 11'(idx);
                    last_written     = idx;
                    cur_col++;
                end
            end
            MODE_SET_CURSOR: begin
                cur_row   = (cmd.new_row > TCW_ROWS - 1) ? TCW_ROWS - 1 : int'(cmd.new_row);
                cur_col   = (cmd.new_column > TCW_COLS) ? TCW_COLS : int'(cmd.new_column);
                cur_color = cmd.new_color;
            end
            MODE_CLEAR: begin
                for (idx = 0; idx < CELLS; idx++) begin
                    screen_char[idx] = CH_SPACE;
                end
                cur_row   = 1;
                cur_col   = 0;
                cur_color = clear_color;
            end
            default: begin
                if (cmd.cell_index < CELLS) begin
                    r.read_char = screen_char[cmd.cell_index];
                    r.read_attr = screen_attr[cmd.cell_index];
                end
            end
        endcase
        r.cursor_row_now    = 5'(cur_row);
        r.cursor_column_now = 7'(cur_col);
        return r;
    endfunction

    // Sender gaps: mostly none or short, a few long, with runs of back-to-back transactions.
    function automatic int idle_gap();
        int pick;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (pick < 55) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_item random_fill();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[$bits(t_item)-1:0];
    endfunction

    function automatic t_item mk_put(input logic [7:0] ch, input logic last);
        t_item c;
        c              = '0;
        c.mode         = MODE_PUT_CHAR;
        c.char_code    = ch;
        c.last_in_call = last;
        return c;
    endfunction

    function automatic t_item mk_set(input logic [4:0] row, input logic [6:0] col,
                                     input logic [7:0] colour);
        t_item c;
        c            = '0;
        c.mode       = MODE_SET_CURSOR;
        c.new_row    = row;
        c.new_column = col;
        c.new_color  = colour;
        return c;
    endfunction

    function automatic t_item mk_read(input logic [10:0] idx);
        t_item c;
        c            = '0;
        c.mode       = MODE_READ_CELL;
        c.cell_index = idx;
        return c;
    endfunction

    function automatic t_item mk_clear();
        t_item c;
        c      = '0;
        c.mode = MODE_CLEAR;
        return c;
    endfunction

    function automatic t_result mk_res(input logic [7:0] rc, input logic [7:0] ra,
                                       input logic [4:0] row, input logic [6:0] col,
                                       input logic wrote, input logic [10:0] widx,
                                       input logic scr, input logic done);
        t_result r;
        r.read_char         = rc;
        r.read_attr         = ra;
        r.cursor_row_now    = row;
        r.cursor_column_now = col;
        r.wrote_cell        = wrote;
        r.written_index     = widx;
        r.scrolled          = scr;
        r.call_done         = done;
        return r;
    endfunction

    // Offer one command after a random gap and hold it until the engine takes it.
    task automatic send_item(input t_item cmd, input logic fixed, input t_result fixed_res);
        int      gap;
        t_result predicted;
        gap = idle_gap();
        repeat (gap) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item  <= cmd;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        predicted = apply_command(cmd);
        due_results.push_back(fixed ? fixed_res : predicted);
    endtask

    // Let every outstanding result arrive and the engine settle.
    task automatic wait_quiet();
        i_start <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        while (o_busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic set_default_colour(input logic [7:0] colour);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= colour;
        @(posedge i_clk);
        clear_color = colour;
        i_cfg_we   <= 1'b0;
    endtask

    // Random traffic: mostly write calls of random text, with cursor moves, reads near the
    // text just written, the odd clear, and some broken calls and raw noise.
    task automatic run_random(input int n_items);
        int    sent;
        int    pick;
        int    len;
        int    k;
        bit    broken;
        t_item cmd;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100)
                                                  : $urandom_range(1, 12);
                broken = ($urandom_range(0, 9) == 0);
                for (k = 0; k < len; k++) begin
                    cmd      = random_fill();
                    cmd.mode = MODE_PUT_CHAR;
                    pick     = $urandom_range(0, 99);
                    if (pick < 6) cmd.char_code = CH_LF;
                    else if (pick < 9) cmd.char_code = CH_CR;
                    if (!broken) cmd.last_in_call = (k == len - 1);
                    send_item(cmd, 1'b0, '0);
                end
                sent += len;
            end else if (pick < 70) begin
                cmd      = random_fill();
                cmd.mode = MODE_SET_CURSOR;
                if ($urandom_range(0, 9) < 7) cmd.new_row = $urandom_range(0, TCW_ROWS - 1);
                case ($urandom_range(0, 3))
                    0, 1: cmd.new_column = $urandom_range(0, TCW_COLS);
                    2: cmd.new_column = $urandom_range(TCW_COLS - 8, TCW_COLS);
                    default: ;
                endcase
                send_item(cmd, 1'b0, '0);
                sent++;
            end else if (pick < 96) begin
                cmd      = random_fill();
                cmd.mode = MODE_READ_CELL;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: begin
                        k = last_written - $urandom_range(0, 6);
                        cmd.cell_index = (k < 0) ? 0 : k;
                    end
                    6, 7, 8: cmd.cell_index = $urandom_range(0, CELLS - 1);
                    default: ;
                endcase
                send_item(cmd, 1'b0, '0);
                sent++;
            end else if (pick < 98) begin
                cmd      = random_fill();
                cmd.mode = MODE_CLEAR;
                send_item(cmd, 1'b0, '0);
                sent++;
            end else begin
                send_item(random_fill(), 1'b0, '0);
                sent++;
            end
        end
    endtask

    // Check every result transaction against the oldest one due.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (due_results.size() == 0) begin
                report_mismatch("result with nothing due", '0, '0);
            end else begin
                compare_result(o_result, due_results.pop_front());
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int        p;
        int        n;
        t_step_row steps [$];

        for (n = 0; n < CELLS; n++) begin
            screen_char[n] = CH_SPACE;
            screen_attr[n] = RESET_ATTR;
        end
        cur_row      = 1;
        cur_col      = 0;
        cur_color    = RESET_ATTR;
        clear_color  = RESET_ATTR;
        last_written = 0;

        // Reset, then wait out the clearing pass.
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_quiet();
        set_default_colour(8'h00);

        // Directed table: power-on screen, out-of-range reads, clamped cursor,
        // wrap into a scroll, line controls, the fixed top row, and clear.
        steps.push_back('{mk_read(11'd0), 1'b1, mk_res(8'h20, 8'h07, 1, 0, 0, 0, 0, 0)});
        steps.push_back('{mk_read(11'd1999), 1'b1, mk_res(8'h20, 8'h07, 1, 0, 0, 0, 0, 0)});
        steps.push_back('{mk_read(11'd2000), 1'b1, mk_res(8'h00, 8'h00, 1, 0, 0, 0, 0, 0)});
        steps.push_back('{mk_read(11'd2047), 1'b1, mk_res(8'h00, 8'h00, 1, 0, 0, 0, 0, 0)});
        steps.push_back('{mk_put(8'h41, 1'b1), 1'b1, mk_res(0, 0, 1, 1, 1, 80, 0, 1)});
        steps.push_back('{mk_read(11'd80), 1'b0, '0});
        steps.push_back('{mk_put(CH_CR, 1'b0), 1'b1, mk_res(0, 0, 1, 0, 0, 0, 0, 0)});
        steps.push_back('{mk_set(5'd31, 7'd127, 8'hFF), 1'b1, mk_res(0, 0, 24, 80, 0, 0, 0, 0)});
        steps.push_back('{mk_put(8'hFF, 1'b1), 1'b1, mk_res(0, 0, 24, 1, 1, 1920, 1, 1)});
        steps.push_back('{mk_read(11'd1920), 1'b0, '0});
        steps.push_back('{mk_read(11'd80), 1'b0, '0});
        steps.push_back('{mk_put(CH_LF, 1'b0), 1'b1, mk_res(0, 0, 24, 0, 0, 0, 1, 0)});
        steps.push_back('{mk_read(11'd1840), 1'b0, '0});
        steps.push_back('{mk_set(5'd0, 7'd0, 8'h00), 1'b1, mk_res(0, 0, 0, 0, 0, 0, 0, 0)});
        steps.push_back('{mk_put(8'h00, 1'b0), 1'b1, mk_res(0, 0, 0, 1, 1, 0, 0, 0)});
        steps.push_back('{mk_set(5'd24, 7'd79, 8'h5A), 1'b1, mk_res(0, 0, 24, 79, 0, 0, 0, 0)});
        steps.push_back('{mk_put(8'h5A, 1'b0), 1'b1, mk_res(0, 0, 24, 80, 1, 1999, 0, 0)});
        steps.push_back('{mk_put(CH_LF, 1'b0), 1'b1, mk_res(0, 0, 24, 0, 0, 0, 1, 0)});
        steps.push_back('{mk_read(11'd0), 1'b0, '0});
        steps.push_back('{mk_read(11'd1999), 1'b0, '0});
        steps.push_back('{mk_clear(), 1'b1, mk_res(0, 0, 1, 0, 0, 0, 0, 0)});
        steps.push_back('{mk_read(11'd1920), 1'b0, '0});
        steps.push_back('{mk_put(8'h78, 1'b1), 1'b1, mk_res(0, 0, 1, 1, 1, 80, 0, 1)});
        steps.push_back('{mk_read(11'd80), 1'b0, '0});
        steps.push_back('{mk_set(5'd5, 7'd80, 8'h3C), 1'b1, mk_res(0, 0, 5, 80, 0, 0, 0, 0)});
        steps.push_back('{mk_put(8'h71, 1'b0), 1'b1, mk_res(0, 0, 6, 1, 1, 480, 0, 0)});
        for (n = 0; n < steps.size(); n++) begin
            send_item(steps[n].cmd, steps[n].fixed, steps[n].res);
        end

        // Random phases, each under its own clear colour.
        for (p = 0; p < 4; p++) begin
            wait_quiet();
            case (p)
                0: set_default_colour(8'hFF);
                1: set_default_colour($urandom_range(1, 254));
                2: set_default_colour(8'h00);
                default: set_default_colour(RESET_ATTR);
            endcase
            run_random(PHASE_ITEMS);
        end

        wait_quiet();
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
